[sv/fpba_pkg.sv]
// ----------------------------------------------------------------------------
// fpba_pkg
// Types and constants shared by the fit-policy block allocator files.
// ----------------------------------------------------------------------------
package fpba_pkg;

   localparam int SIZE_W  = 16;
   localparam int IDX_W   = 8;
   localparam int COUNT_W = 5;
   localparam int MODE_W  = 2;
   localparam int DATA_W  = 32;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_ALLOC = 1'b1;

   localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

   localparam logic REG_FIT_MODE    = 1'b0;
   localparam logic REG_BLOCK_COUNT = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

   typedef struct packed {
      logic              action;
      logic [3:0]        block_index;
      logic [SIZE_W-1:0] size;
   } req_type;

   typedef struct packed {
      logic              granted;
      logic [3:0]        chosen_block;
      logic [SIZE_W-1:0] remaining_size;
   } rsp_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic              active;
      logic              found;
      logic [IDX_W-1:0]  idx;
      logic [SIZE_W-1:0] size;
   } tok_type;

   // table write broadcast to all cells
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
      logic [SIZE_W-1:0] data;
   } wr_type;

endpackage

[sv/fit_policy_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit
// Free-size table with first, best and worst fit placement.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready): action 0 loads block_index with size; action 1
//   asks for size bytes. rsp channel (valid/ready) returns one item per
//   request item: granted, chosen_block, remaining_size.
//   APB port: 0x0 fit_mode (0 first, 1 best, 2 worst), 0x4 block_count.
//   Write registers only while no item is in flight.
// Flow:
//   A load result is registered and valid in the cycle after the accepting
//   edge; loads can follow back to back while results are taken.
//   A request launches the search token, which walks the row of NUM_BLOCKS
//   cells, one cell per cycle; then the result is registered and the chosen
//   entry is updated. The next item can be accepted once that result is
//   taken, or in the same cycle as it is taken.
//   One item is in work at a time.
// Reset: fit_mode 0, block_count 16, no item in work. Table entries are
//   undefined until loaded.
// Stall: a waiting result sits in the output register; req_ready stays low
//   until that result is taken (or is taken in the same cycle).
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_unit #(
   parameter int NUM_BLOCKS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fpba_pkg::req_type    req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fpba_pkg::rsp_type    rsp_payload,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import fpba_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [MODE_W-1:0]  mode_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [SIZE_W-1:0]  want_ff, want_in;
   logic               launch_ff, launch_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   tok_type            tok_chain [0:NUM_BLOCKS];
   logic [NUM_BLOCKS:0] tok_active;
   wr_type             wr;

   logic req_fire;
   logic load_fire;
   logic alloc_fire;
   logic finish;
   logic load_ok;
   logic csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == REG_BLOCK_COUNT) ? DATA_W'(count_ff) : DATA_W'(mode_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_FIRST;
         count_ff <= COUNT_RESET;
      end else if (csr_write) begin
         if (paddr[2] == REG_FIT_MODE) begin
            mode_ff <= pwdata[MODE_W-1:0];
         end else begin
            count_ff <= pwdata[COUNT_W-1:0];
         end
      end
   end

   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire   = req_valid && req_ready;
   assign load_fire  = req_fire && (req_payload.action == ACT_LOAD);
   assign alloc_fire = req_fire && (req_payload.action == ACT_ALLOC);
   assign finish     = (state_ff == ST_SCAN) && tok_chain[NUM_BLOCKS].active;
   assign load_ok    = 32'(req_payload.block_index) < NUM_BLOCKS;

   assign tok_chain[0] = '{active: launch_ff, found: 1'b0, idx: '0, size: '0};

   genvar gi;
   generate
      for (gi = 0; gi < NUM_BLOCKS; gi++) begin : g_cell
         fpba_cell #(
            .CELL_IDX (gi)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .tok_in  (tok_chain[gi]),
            .tok_out (tok_chain[gi+1]),
            .wr      (wr),
            .want    (want_ff),
            .mode    (mode_ff),
            .count   (count_ff)
         );
      end
      for (gi = 0; gi <= NUM_BLOCKS; gi++) begin : g_act
         assign tok_active[gi] = tok_chain[gi].active;
      end
   endgenerate

   always_comb begin
      wr           = '{en: 1'b0, idx: '0, data: '0};
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      state_in     = state_ff;
      want_in      = want_ff;
      launch_in    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (load_fire) begin
               wr.en          = load_ok;
               wr.idx         = IDX_W'(req_payload.block_index);
               wr.data        = req_payload.size;
               rsp_in.granted = 1'b0;
               rsp_in.chosen_block   = req_payload.block_index;
               rsp_in.remaining_size = load_ok ? req_payload.size : '0;
               rsp_valid_in   = 1'b1;
            end else if (alloc_fire) begin
               want_in   = req_payload.size;
               launch_in = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (finish) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (tok_chain[NUM_BLOCKS].found) begin
                  wr.en   = 1'b1;
                  wr.idx  = tok_chain[NUM_BLOCKS].idx;
                  wr.data = tok_chain[NUM_BLOCKS].size - want_ff;
                  rsp_in.granted        = 1'b1;
                  rsp_in.chosen_block   = tok_chain[NUM_BLOCKS].idx[3:0];
                  rsp_in.remaining_size = tok_chain[NUM_BLOCKS].size - want_ff;
               end else begin
                  rsp_in = '{granted: 1'b0, chosen_block: '0, remaining_size: '0};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff <= want_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // scan never overlaps a waiting result
   a_scan_no_rsp : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !rsp_valid_ff)
      else $error("result pending during scan");

   // exactly one search token in flight while scanning
   a_one_token : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ($countones(tok_active) == 1))
      else $error("search token lost or duplicated");

   // no token outside a scan
   a_idle_no_token : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (tok_active == '0))
      else $error("stray search token");

   // end of scan always produces a result
   a_finish_rsp : assert property (@(posedge clock) disable iff (reset)
      finish |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("scan finished without result");

endmodule

[sv/fpba_cell.sv]
// ----------------------------------------------------------------------------
// fpba_cell
// One table entry: holds a free size and updates the passing search token.
// ----------------------------------------------------------------------------
module fpba_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  fpba_pkg::tok_type              tok_in,
   output fpba_pkg::tok_type              tok_out,
   input  fpba_pkg::wr_type               wr,
   input  logic [fpba_pkg::SIZE_W-1:0]    want,
   input  logic [fpba_pkg::MODE_W-1:0]    mode,
   input  logic [fpba_pkg::COUNT_W-1:0]   count
);
   import fpba_pkg::*;

   logic [SIZE_W-1:0] free_ff;
   logic              active_ff;
   logic              found_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [SIZE_W-1:0] size_ff;

   logic in_range;
   logic fits;
   logic take;

   assign in_range = 32'(count) > CELL_IDX;
   assign fits     = in_range && (free_ff >= want);

   always_comb begin
      take = 1'b0;
      if (fits) begin
         if (!tok_in.found) begin
            take = 1'b1;
         end else if (mode == MODE_BEST) begin
            take = free_ff < tok_in.size;
         end else if (mode == MODE_WORST) begin
            take = free_ff > tok_in.size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.idx == IDX_W'(CELL_IDX))) begin
         free_ff <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= tok_in.active;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= tok_in.found | take;
      idx_ff   <= take ? IDX_W'(CELL_IDX) : tok_in.idx;
      size_ff  <= take ? free_ff : tok_in.size;
   end

   assign tok_out = '{active: active_ff, found: found_ff, idx: idx_ff, size: size_ff};

endmodule

[dv/tb_fit_policy_block_allocator_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fit_policy_block_allocator_unit
// Self-checking bench for the first/best/worst fit block allocator.
// Loads the free-size table, then drives placement requests under every
// policy and a range of block counts through the req/rsp handshakes. Random gaps and
// output stalls are applied. A local model of the table predicts each
// response, and every response is compared field by field in arrival order.
// Register writes happen only with no item in flight and are read back.
// ----------------------------------------------------------------------------
module tb_fit_policy_block_allocator_unit;
   import fpba_pkg::*;

   localparam int NUM_BLOCKS = 16;
   localparam logic [2:0] FIT_MODE_ADDR = {REG_FIT_MODE, 2'b00};
   localparam logic [2:0] COUNT_ADDR    = {REG_BLOCK_COUNT, 2'b00};
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // local copy of block state
   logic [SIZE_W-1:0]  free_left [NUM_BLOCKS];
   logic [MODE_W-1:0]  policy = MODE_FIRST;
   logic [COUNT_W-1:0] blocks_in_use = COUNT_RESET;

   rsp_type owed_placements [$];
   int      mismatch_count = 0;
   int      rsp_seen = 0;
   int      stall_left = 0;
   bit      idle_on = 1'b1;

   fit_policy_block_allocator_unit #(.NUM_BLOCKS(NUM_BLOCKS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #5 clock = ~clock;

   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 100) begin
         $display("ERROR %0t: %s", $time, msg);
      end
   endtask

   // applies one item to the local table and returns the response it owes
   function automatic rsp_type place_in_table(input req_type it);
      rsp_type r;
      int      limit;
      int      pick;
      r = '0;
      if (it.action == ACT_LOAD) begin
         r.chosen_block = it.block_index;
         if (int'(it.block_index) < NUM_BLOCKS) begin
            free_left[it.block_index] = it.size;
            r.remaining_size = it.size;
         end
      end else begin
         limit = (int'(blocks_in_use) > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks_in_use);
         pick = -1;
         for (int j = 0; j < limit; j++) begin
            if (free_left[j] >= it.size) begin
               if (pick < 0) begin
                  pick = j;
                  if (policy != MODE_BEST && policy != MODE_WORST) break;
               end else if (policy == MODE_BEST && free_left[j] < free_left[pick]) begin
                  pick = j;
               end else if (policy == MODE_WORST && free_left[j] > free_left[pick]) begin
                  pick = j;
               end
            end
         end
         if (pick >= 0) begin
            free_left[pick] = free_left[pick] - it.size;
            r.granted = 1'b1;
            r.chosen_block = 4'(pick);
            r.remaining_size = free_left[pick];
         end
      end
      return r;
   endfunction

   task automatic send_item(input logic act, input logic [3:0] idx, input logic [15:0] sz);
      req_type item;
      int      gap;
      int      roll;
      item.action = act;
      item.block_index = idx;
      item.size = sz;
      gap = 0;
      if (idle_on) begin
         roll = $urandom_range(0, 99);
         if (roll < 50) gap = 0;
         else if (roll < 88) gap = $urandom_range(1, 3);
         else if (roll < 97) gap = $urandom_range(4, 12);
         else gap = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      owed_placements.push_back(place_in_table(item));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (owed_placements.size() != 0);
   endtask

   task automatic csr_read(input logic [2:0] addr, input logic [31:0] want);
      logic [31:0] mask;
      mask = (addr == FIT_MODE_ADDR) ? 32'h3 : 32'h1F;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if ((prdata & mask) !== (want & mask)) begin
         report_mismatch($sformatf("csr 0x%0h read 0x%0h, want 0x%0h", addr, prdata & mask,
                                   want & mask));
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == FIT_MODE_ADDR) policy = val[MODE_W-1:0];
      else blocks_in_use = val[COUNT_W-1:0];
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      csr_read(addr, val);
   endtask

   task automatic set_config(input logic [MODE_W-1:0] mode, input logic [COUNT_W-1:0] cnt);
      drain_results();
      csr_write(FIT_MODE_ADDR, 32'(mode));
      csr_write(COUNT_ADDR, 32'(cnt));
   endtask

   task automatic test_reset_values();
      csr_read(FIT_MODE_ADDR, 32'(MODE_FIRST));
      csr_read(COUNT_ADDR, 32'(COUNT_RESET));
   endtask

   task automatic test_table_load();
      logic [15:0] sizes [NUM_BLOCKS];
      sizes = '{16'd0, 16'd100, 16'hFFFF, 16'd100, 16'h5555, 16'hAAAA, 16'd40, 16'd40,
                16'd7, 16'hFFFF, 16'd300, 16'd1, 16'd2, 16'h8000, 16'h7FFF, 16'd9};
      for (int j = 0; j < NUM_BLOCKS; j++) begin
         send_item(ACT_LOAD, 4'(j), sizes[j]);
      end
   endtask

   // reset policy and count: zero-size item, partial fit, full drain of a block
   task automatic test_first_fit();
      send_item(ACT_ALLOC, 4'hF, 16'd0);
      send_item(ACT_ALLOC, 4'h0, 16'd50);
      send_item(ACT_ALLOC, 4'h5, 16'hFFFF);
   endtask

   task automatic test_best_fit();
      set_config(MODE_BEST, 5'd16);
      send_item(ACT_ALLOC, 4'h0, 16'd30);
      send_item(ACT_ALLOC, 4'hA, 16'hFFFF);
   endtask

   task automatic test_worst_fit();
      set_config(MODE_WORST, 5'd16);
      send_item(ACT_ALLOC, 4'h3, 16'd1);
   endtask

   // spare policy code, no blocks searched, count past the table, one block
   task automatic test_policy_and_count_edges();
      set_config(MODE_SPARE, 5'd0);
      send_item(ACT_ALLOC, 4'h0, 16'd0);
      set_config(MODE_SPARE, 5'd31);
      send_item(ACT_ALLOC, 4'hF, 16'd60000);
      send_item(ACT_ALLOC, 4'h7, 16'd8);
      set_config(MODE_BEST, 5'd1);
      send_item(ACT_ALLOC, 4'h9, 16'd0);
   endtask

   task automatic test_random_traffic();
      int                 roll;
      int                 base;
      int                 want;
      logic [COUNT_W-1:0] cnt;
      logic [15:0]        sz;
      for (int phase = 0; phase < 17; phase++) begin
         roll = $urandom_range(0, 9);
         case (roll)
            0: cnt = 5'd0;
            1: cnt = 5'd1;
            2: cnt = 5'd16;
            3: cnt = 5'd31;
            4: cnt = 5'd17;
            default: cnt = 5'($urandom_range(1, NUM_BLOCKS));
         endcase
         set_config(MODE_W'($urandom_range(0, 3)), cnt);
         idle_on = (phase % 4 != 3);
         for (int n = 0; n < 65; n++) begin
            if ($urandom_range(0, 99) < 5) begin
               repeat ($urandom_range(4, 16)) begin
                  send_item(ACT_LOAD, 4'($urandom_range(0, 15)), 16'($urandom));
               end
            end
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
               roll = $urandom_range(0, 99);
               if (roll < 50) sz = 16'($urandom);
               else if (roll < 75) sz = 16'($urandom_range(0, 512));
               else sz = free_left[$urandom_range(0, NUM_BLOCKS - 1)];
               send_item(ACT_LOAD, 4'($urandom_range(0, 15)), sz);
            end else begin
               base = int'(free_left[$urandom_range(0, NUM_BLOCKS - 1)]);
               roll = $urandom_range(0, 99);
               if (roll < 8) want = 0;
               else if (roll < 30) want = base;
               else if (roll < 70) want = $urandom_range(0, base);
               else if (roll < 80) want = (base < 65535) ? base + 1 : base;
               else want = $urandom_range(0, 65535);
               send_item(ACT_ALLOC, 4'($urandom_range(0, 15)), 16'(want));
            end
         end
      end
      idle_on = 1'b1;
   endtask

   // output side stalls
   always @(posedge clock) begin
      if (!idle_on) begin
         stall_left = 0;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         case ($urandom_range(0, 99)) inside
            [0:69]:  rsp_ready <= 1'b1;
            [70:92]: begin stall_left = $urandom_range(0, 2);   rsp_ready <= 1'b0; end
            [93:97]: begin stall_left = $urandom_range(3, 11);  rsp_ready <= 1'b0; end
            default: begin stall_left = $urandom_range(19, 59); rsp_ready <= 1'b0; end
         endcase
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_placements.size() == 0) begin
            report_mismatch($sformatf("item %0d arrived with nothing outstanding", rsp_seen));
         end else begin
            want = owed_placements.pop_front();
            if (rsp_payload.granted !== want.granted) begin
               report_mismatch($sformatf("item %0d granted %0b, want %0b", rsp_seen,
                                         rsp_payload.granted, want.granted));
            end
            if (rsp_payload.chosen_block !== want.chosen_block) begin
               report_mismatch($sformatf("item %0d chosen_block %0d, want %0d", rsp_seen,
                                         rsp_payload.chosen_block, want.chosen_block));
            end
            if (rsp_payload.remaining_size !== want.remaining_size) begin
               report_mismatch($sformatf("item %0d remaining_size %0d, want %0d", rsp_seen,
                                         rsp_payload.remaining_size, want.remaining_size));
            end
         end
         rsp_seen++;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_table_load();
      test_first_fit();
      test_best_fit();
      test_worst_fit();
      test_policy_and_count_edges();
      test_random_traffic();
      drain_results();
      repeat (NUM_BLOCKS + 4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
